FILE: hw/rtl/pamb_pkg.sv
// ----------------------------------------------------------------------------
// pamb_pkg: shared types and constants of the per-account priority mailbox
// Sizes, status codes, operation codes and the account cell control bundle.
// ----------------------------------------------------------------------------
package pamb_pkg;

  localparam int ACCOUNTS = 16;
  localparam int MESSAGES = 64;
  localparam int ACC_W    = $clog2(ACCOUNTS);
  localparam int SLOT_W   = $clog2(MESSAGES);
  localparam int PTR_W    = $clog2(MESSAGES + 1);

  localparam logic [PTR_W-1:0] NIL      = PTR_W'(MESSAGES);
  localparam logic [3:0]       MAX_PRIO = 4'd9;

  localparam logic [1:0] FN_REGISTER = 2'd0;
  localparam logic [1:0] FN_DELIVER  = 2'd1;
  localparam logic [1:0] FN_REMOVE   = 2'd2;
  localparam logic [1:0] FN_FETCH    = 2'd3;

  localparam logic [3:0] ST_REGISTERED = 4'd0;
  localparam logic [3:0] ST_EXISTS     = 4'd1;
  localparam logic [3:0] ST_INVALID    = 4'd2;
  localparam logic [3:0] ST_DELIVERED  = 4'd3;
  localparam logic [3:0] ST_BADPRIO    = 4'd4;
  localparam logic [3:0] ST_MISSING    = 4'd5;
  localparam logic [3:0] ST_REMOVED    = 4'd6;
  localparam logic [3:0] ST_EMPTY      = 4'd7;
  localparam logic [3:0] ST_FETCHED    = 4'd8;
  localparam logic [3:0] ST_FULL       = 4'd9;

  // write bundle broadcast to every account cell; only the selected one acts
  typedef struct packed {
    logic [ACC_W-1:0] sel;
    logic             we;
    logic             valid;
    logic [15:0]      ident;
    logic             head_we;
    logic [PTR_W-1:0] head;
  } acct_ctl_t;

endpackage

FILE: hw/rtl/pamb_acct_cell.sv
// ----------------------------------------------------------------------------
// pamb_acct_cell: one entry of the account table
// Holds valid, id and inbox head; compares the search id and passes the
// first-free token on to its right neighbor.
// ----------------------------------------------------------------------------
module pamb_acct_cell import pamb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [ACC_W-1:0] cell_idx_i,
  input  acct_ctl_t        ctl_i,
  input  logic [15:0]      srch_id_i,
  input  logic             free_in_i,
  output logic             free_out_o,
  output logic             take_o,
  output logic             hit_o,
  output logic [PTR_W-1:0] head_o
);

  logic             valid_q;
  logic [15:0]      ident_q;
  logic [PTR_W-1:0] head_q;
  logic             sel;

  assign sel        = (ctl_i.sel == cell_idx_i);
  assign hit_o      = valid_q && (ident_q == srch_id_i);
  assign take_o     = !valid_q && !free_in_i;
  assign free_out_o = free_in_i || !valid_q;
  assign head_o     = head_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      head_q  <= NIL;
    end else begin
      if (sel && ctl_i.we) begin
        valid_q <= ctl_i.valid;
      end
      if (sel && ctl_i.head_we) begin
        head_q <= ctl_i.head;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (sel && ctl_i.we) begin
      ident_q <= ctl_i.ident;
    end
  end

endmodule

FILE: hw/rtl/per_account_priority_mailbox_top.sv
// ----------------------------------------------------------------------------
// per_account_priority_mailbox_top: per-account priority mailbox
// Account table as a row of cells, message pool as linked lists in memory.
// ----------------------------------------------------------------------------
// One request at a time. Deliver, remove and fetch first search the account
// row. Deliver then pops the free list and walks the account's inbox past
// every message with priority not lower than the new one, then writes and
// links the new slot. Remove walks the whole inbox. The walk is set by the
// single read port of the slot memory, whose read data is registered:
// address, read and test are separate states for each message. A result
// sits in an output register; the next request is taken once the previous
// result has been handed over to that register, so a stalled receiver holds
// off the input.
// max_account_id lies at byte address 0 of the APB port.
// ----------------------------------------------------------------------------
module per_account_priority_mailbox_top import pamb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [15:0] account_id_i,
  input  logic [3:0]  priority_req_i,
  input  logic [15:0] message_handle_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  status_o,
  output logic [15:0] fetched_handle_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_LOOK, S_DF_REQ, S_DF_CHK, S_DW_TEST, S_DW_REQ, S_DW_CHK,
    S_D_INS, S_D_LINK, S_RM_TEST, S_RM_REQ, S_RM_CHK, S_FT_REQ, S_FT_CHK,
    S_DONE
  } state_e;

  // config register
  logic [15:0] max_id_q;
  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {16'd0, max_id_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_id_q <= 16'd1023;
    end else if (psel && penable && pwrite && (paddr == 2'd0)) begin
      max_id_q <= pwdata[15:0];
    end
  end

  state_e           state_q;
  logic [1:0]       func_q;
  logic [15:0]      id_q;
  logic [3:0]       prio_q;
  logic [15:0]      msg_q;
  logic [ACC_W-1:0] acct_q;
  logic [PTR_W-1:0] ptr_q, cur_q, prev_q, slot_q, free_head_q;
  logic [3:0]       prev_prio_q;
  logic [3:0]       res_st_q;
  logic [15:0]      res_hdl_q;
  logic             out_valid_q;
  logic [3:0]       out_st_q;
  logic [15:0]      out_hdl_q;

  // account cell row
  acct_ctl_t        ctl;
  logic [ACCOUNTS:0] free_chain;
  logic [ACCOUNTS-1:0] hit, take;
  logic [PTR_W-1:0] head [ACCOUNTS];
  logic [ACC_W-1:0] hit_idx, take_idx;
  logic [PTR_W-1:0] hit_head;
  logic             hit_any;

  assign free_chain[0] = 1'b0;

  for (genvar k = 0; k < ACCOUNTS; k++) begin : g_cell
    pamb_acct_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (ACC_W'(k)),
      .ctl_i      (ctl),
      .srch_id_i  (id_q),
      .free_in_i  (free_chain[k]),
      .free_out_o (free_chain[k+1]),
      .take_o     (take[k]),
      .hit_o      (hit[k]),
      .head_o     (head[k])
    );
  end

  always_comb begin
    hit_idx  = '0;
    take_idx = '0;
    hit_head = '0;
    for (int k = 0; k < ACCOUNTS; k++) begin
      if (hit[k]) begin
        hit_idx  = hit_idx | ACC_W'(k);
        hit_head = hit_head | head[k];
      end
      if (take[k]) begin
        take_idx = take_idx | ACC_W'(k);
      end
    end
  end
  assign hit_any = |hit;

  // slot pool memory: handle, and {priority, next}
  logic [15:0]       hdl_mem [MESSAGES];
  logic [3:0]        prio_mem [MESSAGES];
  logic [PTR_W-1:0]  next_mem [MESSAGES];
  logic [MESSAGES-1:0] next_wr_q;  // next link written since reset
  logic              mem_we, hdl_we;
  logic [SLOT_W-1:0] waddr;
  logic [3:0]        wprio;
  logic [PTR_W-1:0]  wnext;
  logic [15:0]       rd_hdl_q;
  logic [3:0]        rd_prio_q;
  logic [PTR_W-1:0]  rd_next_q;
  logic              rd_nv_q;
  logic [SLOT_W-1:0] rd_addr_q;
  logic [PTR_W-1:0]  next_eff;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      prio_mem[waddr] <= wprio;
      next_mem[waddr] <= wnext;
      if (hdl_we) begin
        hdl_mem[waddr] <= msg_q;
      end
    end
    rd_hdl_q  <= hdl_mem[ptr_q[SLOT_W-1:0]];
    rd_prio_q <= prio_mem[ptr_q[SLOT_W-1:0]];
    rd_next_q <= next_mem[ptr_q[SLOT_W-1:0]];
    rd_addr_q <= ptr_q[SLOT_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_wr_q <= '0;
      rd_nv_q   <= 1'b0;
    end else begin
      if (mem_we) begin
        next_wr_q[waddr] <= 1'b1;
      end
      rd_nv_q <= next_wr_q[ptr_q[SLOT_W-1:0]];
    end
  end

  // unwritten links still follow the reset free-list chain
  assign next_eff = rd_nv_q ? rd_next_q : ({1'b0, rd_addr_q} + PTR_W'(1));

  // memory writes and cell writes per state
  always_comb begin
    mem_we = 1'b0;
    hdl_we = 1'b0;
    waddr  = '0;
    wprio  = '0;
    wnext  = '0;
    ctl    = '0;
    ctl.ident = id_q;
    case (state_q)
      S_LOOK: begin
        if (func_q == FN_REGISTER && id_q <= max_id_q && !hit_any
            && free_chain[ACCOUNTS]) begin
          ctl.sel     = take_idx;
          ctl.we      = 1'b1;
          ctl.valid   = 1'b1;
          ctl.head_we = 1'b1;
          ctl.head    = NIL;
        end
      end
      S_D_INS: begin
        mem_we = 1'b1;
        hdl_we = 1'b1;
        waddr  = slot_q[SLOT_W-1:0];
        wprio  = prio_q;
        wnext  = cur_q;
        if (prev_q == NIL) begin
          ctl.sel     = acct_q;
          ctl.head_we = 1'b1;
          ctl.head    = slot_q;
        end
      end
      S_D_LINK: begin
        mem_we = 1'b1;
        waddr  = prev_q[SLOT_W-1:0];
        wprio  = prev_prio_q;
        wnext  = slot_q;
      end
      S_RM_TEST: begin
        if (cur_q == NIL) begin
          ctl.sel     = acct_q;
          ctl.we      = 1'b1;
          ctl.valid   = 1'b0;
          ctl.head_we = 1'b1;
          ctl.head    = NIL;
        end
      end
      S_RM_CHK, S_FT_CHK: begin
        mem_we = 1'b1;
        waddr  = cur_q[SLOT_W-1:0];
        wprio  = rd_prio_q;
        wnext  = free_head_q;
        if (state_q == S_FT_CHK) begin
          ctl.sel     = acct_q;
          ctl.head_we = 1'b1;
          ctl.head    = next_eff;
        end
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      free_head_q <= '0;
      out_valid_q <= 1'b0;
      ptr_q       <= '0;
    end else begin
      // drain the output register unless a new result loads it this cycle
      if (out_valid_q && !out_stall_i && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            func_q  <= func_i;
            id_q    <= account_id_i;
            prio_q  <= priority_req_i;
            msg_q   <= message_handle_i;
            state_q <= S_LOOK;
          end
        end
        S_LOOK: begin
          acct_q    <= hit_idx;
          cur_q     <= hit_head;
          res_hdl_q <= '0;
          state_q   <= S_DONE;
          case (func_q)
            FN_REGISTER: begin
              if (id_q > max_id_q)            res_st_q <= ST_INVALID;
              else if (hit_any)               res_st_q <= ST_EXISTS;
              else if (!free_chain[ACCOUNTS]) res_st_q <= ST_FULL;
              else                            res_st_q <= ST_REGISTERED;
            end
            FN_DELIVER: begin
              if (id_q > max_id_q || !hit_any) res_st_q <= ST_MISSING;
              else if (prio_q > MAX_PRIO)      res_st_q <= ST_BADPRIO;
              else if (free_head_q == NIL)     res_st_q <= ST_FULL;
              else begin
                slot_q  <= free_head_q;
                ptr_q   <= free_head_q;
                state_q <= S_DF_REQ;
              end
            end
            FN_REMOVE: begin
              if (!hit_any) res_st_q <= ST_MISSING;
              else          state_q  <= S_RM_TEST;
            end
            default: begin
              if (id_q > max_id_q || !hit_any) res_st_q <= ST_MISSING;
              else if (hit_head == NIL)        res_st_q <= ST_EMPTY;
              else begin
                ptr_q   <= hit_head;
                state_q <= S_FT_REQ;
              end
            end
          endcase
        end
        S_DF_REQ: state_q <= S_DF_CHK;
        S_DF_CHK: begin
          free_head_q <= next_eff;
          prev_q      <= NIL;
          state_q     <= S_DW_TEST;
        end
        S_DW_TEST: begin
          if (cur_q == NIL) begin
            state_q <= S_D_INS;
          end else begin
            ptr_q   <= cur_q;
            state_q <= S_DW_REQ;
          end
        end
        S_DW_REQ: state_q <= S_DW_CHK;
        S_DW_CHK: begin
          if (rd_prio_q >= prio_q) begin
            prev_q      <= cur_q;
            prev_prio_q <= rd_prio_q;
            cur_q       <= next_eff;
            state_q     <= S_DW_TEST;
          end else begin
            state_q <= S_D_INS;
          end
        end
        S_D_INS: begin
          res_st_q <= ST_DELIVERED;
          state_q  <= (prev_q == NIL) ? S_DONE : S_D_LINK;
        end
        S_D_LINK: state_q <= S_DONE;
        S_RM_TEST: begin
          if (cur_q == NIL) begin
            res_st_q <= ST_REMOVED;
            state_q  <= S_DONE;
          end else begin
            ptr_q   <= cur_q;
            state_q <= S_RM_REQ;
          end
        end
        S_RM_REQ: state_q <= S_RM_CHK;
        S_RM_CHK: begin
          free_head_q <= cur_q;
          cur_q       <= next_eff;
          state_q     <= S_RM_TEST;
        end
        S_FT_REQ: state_q <= S_FT_CHK;
        S_FT_CHK: begin
          free_head_q <= cur_q;
          res_st_q    <= ST_FETCHED;
          res_hdl_q   <= rd_hdl_q;
          state_q     <= S_DONE;
        end
        S_DONE: begin
          // hand result to the output register once it is free
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            out_st_q    <= res_st_q;
            out_hdl_q   <= res_hdl_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o       = (state_q != S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign status_o         = out_st_q;
  assign fetched_handle_o = out_hdl_q;

  // only a fetch result carries a handle
  a_hdl_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_FETCHED) |-> fetched_handle_o == 16'd0)
    else $error("handle set on non-fetch result");

  a_free_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_head_q <= NIL)
    else $error("free head out of range");

  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("second request taken while busy");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= ST_FULL)
    else $error("status code out of range");

endmodule
